// ----- src/xkb_pkg.sv -----
// Shared types, constants and helper functions for the XOR-key base64 encoder.
// No dependencies; every other file of the block but xkb_if imports this package.
`default_nettype none

package xkb_pkg;

   // Repeating key length and the padding character.
   localparam int          XKB_KEY_LEN     = 15;
   localparam logic [6:0]  XKB_PAD_CHAR    = 7'd61;
   // Default depth of the queue between the front and back ends.
   localparam int          XKB_QUEUE_DEPTH = 2;
   // Most characters that one input byte can produce.
   localparam int          XKB_MAX_CHARS   = 4;

   // One queued group of characters produced by one input byte.
   typedef struct packed {
      logic [XKB_MAX_CHARS-1:0][6:0] chars;
      logic [2:0]                    count;
      logic                          last;
   } xkb_entry_type;

   // Key byte at a given key position.
   function automatic logic [7:0] xkb_key_byte(input logic [3:0] pos);
      logic [7:0] k;
      unique case (pos)
         4'd0:    k = 8'h6D; // m
         4'd1:    k = 8'h30; // 0
         4'd2:    k = 8'h64; // d
         4'd3:    k = 8'h44; // D
         4'd4:    k = 8'h31; // 1
         4'd5:    k = 8'h6E; // n
         4'd6:    k = 8'h67; // g
         4'd7:    k = 8'h47; // G
         4'd8:    k = 8'h34; // 4
         4'd9:    k = 8'h74; // t
         4'd10:   k = 8'h33; // 3
         4'd11:   k = 8'h4B; // K
         4'd12:   k = 8'h33; // 3
         4'd13:   k = 8'h79; // y
         4'd14:   k = 8'h21; // !
         default: k = 8'h6D; // unreachable position reads as the first key byte
      endcase
      return k;
   endfunction

   // Standard base64 alphabet: 6-bit code to 7-bit ASCII.
   function automatic logic [6:0] xkb_b64_char(input logic [5:0] code);
      logic [6:0] c;
      if (code < 6'd26) begin
         c = 7'd65 + {1'b0, code};
      end else if (code < 6'd52) begin
         c = 7'd71 + {1'b0, code};
      end else if (code < 6'd62) begin
         c = {1'b0, code} - 7'd4;
      end else if (code == 6'd62) begin
         c = 7'd43;
      end else begin
         c = 7'd47;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- src/xkb_if.sv -----
// Handshake interfaces for the request (byte) and response (character) channels.
// Depends on nothing; used by the front end, back end and top level.
`default_nettype none

interface xkb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface xkb_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       end_of_text;

   modport source (output valid, output out_char, output end_of_text, input ready);
   modport sink   (input valid, input out_char, input end_of_text, output ready);
endinterface

`default_nettype wire

// ----- src/xkb_front.sv -----
// Front end: accepts message bytes, applies the key and cuts the bit stream
// into base64 characters, padding included. Depends on xkb_pkg and xkb_if.
`default_nettype none

module xkb_front
   import xkb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   xkb_req_if.sink      req,
   output xkb_entry_type wr_entry,
   output logic         wr_valid,
   input  wire logic    full
);

   logic [3:0] key_pos_ff, key_pos_in;
   logic [3:0] pend_ff, pend_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] mod_ff, mod_in;

   logic [7:0] x_byte;
   logic [5:0] code0, code1, left_code;
   logic       two_codes;
   logic [2:0] rem_cnt;
   logic [3:0] rem_bits;
   logic       left_en;
   logic [2:0] nonpad;
   logic [1:0] mod_after;
   logic [1:0] pads;
   logic       accept;

   assign req.ready = !full;
   assign accept    = req.valid && !full;
   assign wr_valid  = accept;

   // Apply the key byte at the current position.
   assign x_byte = req.data_byte ^ xkb_key_byte(key_pos_ff);

   // Cut pending bits plus the new byte into six-bit groups.
   always_comb begin
      code1     = 6'd0;
      two_codes = 1'b0;
      unique case (cnt_ff)
         3'd2: begin
            code0    = {pend_ff[1:0], x_byte[7:4]};
            rem_cnt  = 3'd4;
            rem_bits = x_byte[3:0];
         end
         3'd4: begin
            code0     = {pend_ff, x_byte[7:6]};
            code1     = x_byte[5:0];
            two_codes = 1'b1;
            rem_cnt   = 3'd0;
            rem_bits  = 4'd0;
         end
         default: begin
            code0    = x_byte[7:2];
            rem_cnt  = 3'd2;
            rem_bits = {2'b00, x_byte[1:0]};
         end
      endcase
   end

   // Leftover bits of the final byte are zero-filled on the right.
   assign left_code = (rem_cnt == 3'd4) ? {rem_bits, 2'b00} : {rem_bits[1:0], 4'b0000};
   assign left_en   = req.final_byte && (rem_cnt != 3'd0);
   assign nonpad    = (two_codes ? 3'd2 : 3'd1) + {2'b00, left_en};
   assign mod_after = mod_ff + nonpad[1:0];
   assign pads      = req.final_byte ? (2'd0 - mod_after) : 2'd0;

   // Assemble the queue entry: data characters first, then padding.
   always_comb begin
      wr_entry.chars[0] = xkb_b64_char(code0);
      if (two_codes) begin
         wr_entry.chars[1] = xkb_b64_char(code1);
      end else if (left_en) begin
         wr_entry.chars[1] = xkb_b64_char(left_code);
      end else begin
         wr_entry.chars[1] = XKB_PAD_CHAR;
      end
      wr_entry.chars[2] = XKB_PAD_CHAR;
      wr_entry.chars[3] = XKB_PAD_CHAR;
      wr_entry.count    = nonpad + {1'b0, pads};
      wr_entry.last     = req.final_byte;
   end

   // Next message state; a final byte returns everything to reset values.
   always_comb begin
      key_pos_in = key_pos_ff;
      pend_in    = pend_ff;
      cnt_in     = cnt_ff;
      mod_in     = mod_ff;
      if (accept) begin
         if (req.final_byte) begin
            key_pos_in = 4'd0;
            pend_in    = 4'd0;
            cnt_in     = 3'd0;
            mod_in     = 2'd0;
         end else begin
            key_pos_in = (key_pos_ff >= 4'(XKB_KEY_LEN - 1)) ? 4'd0 : key_pos_ff + 4'd1;
            pend_in    = rem_bits;
            cnt_in     = rem_cnt;
            mod_in     = mod_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff <= 4'd0;
         pend_ff    <= 4'd0;
         cnt_ff     <= 3'd0;
         mod_ff     <= 2'd0;
      end else begin
         key_pos_ff <= key_pos_in;
         pend_ff    <= pend_in;
         cnt_ff     <= cnt_in;
         mod_ff     <= mod_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/xkb_queue.sv -----
// Short first-in first-out queue of character groups between the two ends.
// Depends on xkb_pkg for the entry type.
`default_nettype none

module xkb_queue
   import xkb_pkg::*;
#(
   parameter int DEPTH = XKB_QUEUE_DEPTH
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_valid,
   input  wire xkb_entry_type wr_entry,
   output logic               full,
   output logic               rd_valid,
   output xkb_entry_type      rd_entry,
   input  wire logic          pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   xkb_entry_type          store_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   do_wr, do_rd;

   assign full     = (cnt_ff == DEPTH_CNT);
   assign rd_valid = (cnt_ff != '0);
   assign rd_entry = store_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && !full;
   assign do_rd    = pop && rd_valid;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

`default_nettype wire

// ----- src/xkb_back.sv -----
// Back end: sends the queued characters one per transaction through an
// output register. Depends on xkb_pkg and xkb_if.
`default_nettype none

module xkb_back
   import xkb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          rd_valid,
   input  wire xkb_entry_type rd_entry,
   output logic               pop,
   xkb_rsp_if.source          rsp
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       eot_ff, eot_in;
   logic       load;
   logic       at_end;

   assign rsp.valid       = valid_ff;
   assign rsp.out_char    = char_ff;
   assign rsp.end_of_text = eot_ff;

   // The output register takes a new character when empty or being drained.
   assign load   = !valid_ff || rsp.ready;
   assign at_end = ({1'b0, idx_ff} == (rd_entry.count - 3'd1));
   assign pop    = load && rd_valid && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      eot_in   = eot_ff;
      if (load) begin
         valid_in = rd_valid;
         char_in  = rd_entry.chars[idx_ff];
         eot_in   = rd_entry.last && at_end;
         if (rd_valid) begin
            idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      eot_ff  <= eot_in;
   end

endmodule

`default_nettype wire

// ----- src/xor_key_base64_encoder_core.sv -----
// XOR-key base64 encoder, top level: front end, character queue, back end.
// Streams message bytes in on req and base64 characters out on rsp.
// Channels: req carries data_byte and final_byte; rsp carries out_char and
// end_of_text. A transaction completes on a rising edge with valid and ready.
// Each byte is XORed with the repeating 15-byte key, restarted per message,
// and the resulting bit stream is sent as base64 characters, with the final
// byte closing the message by zero-filling leftover bits and adding '='
// padding. end_of_text marks the last character of each message.
// A byte's characters reach rsp by way of the queue and then the output
// register. The output register sends one character per cycle while the
// queue holds characters and rsp is ready; a byte yields one or two
// characters, and a final byte up to four. The queue of QUEUE_DEPTH
// character groups lets the front end keep taking bytes while rsp stalls;
// req.ready falls only when that queue is full.
// Reset clears the key position, pending bits, queue and the output register's valid bit.
`default_nettype none

module xor_key_base64_encoder_core
   import xkb_pkg::*;
#(
   parameter int QUEUE_DEPTH = XKB_QUEUE_DEPTH
)
(
   input  wire logic clock,
   input  wire logic reset,
   xkb_req_if.sink   req_bus,
   xkb_rsp_if.source rsp_bus
);

   xkb_entry_type wr_entry;
   xkb_entry_type rd_entry;
   logic          wr_valid;
   logic          full;
   logic          rd_valid;
   logic          pop;

   xkb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .wr_entry (wr_entry),
      .wr_valid (wr_valid),
      .full     (full)
   );

   xkb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (wr_valid),
      .wr_entry (wr_entry),
      .full     (full),
      .rd_valid (rd_valid),
      .rd_entry (rd_entry),
      .pop      (pop)
   );

   xkb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .rd_valid (rd_valid),
      .rd_entry (rd_entry),
      .pop      (pop),
      .rsp      (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- dv/xor_key_base64_encoder_core_test.sv -----
// Self-checking testbench for xor_key_base64_encoder_core: byte messages in, characters out.
// Depends on xkb_pkg (src/xkb_pkg.sv) and the channel interfaces (src/xkb_if.sv).
`timescale 1ns / 1ps

module xor_key_base64_encoder_core_test
   import xkb_pkg::*;
();

   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES  = 80;
   localparam int HOLD_AT_CHAR = 20;
   localparam int RANDOM_ITEMS = 100;
   localparam int ROW_COUNT    = 24;

   // Repeating key and the base64 alphabet, held as packed strings.
   localparam logic [8*XKB_KEY_LEN-1:0] MSG_KEY = "m0dD1ngG4t3K3y!";
   localparam logic [8*64-1:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // One directed row; typed rows carry a hand-read four-character result.
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic [31:0] chars;
   } stim_row_type;

   // One expected character on the response channel.
   typedef struct packed {
      logic [6:0] ch;
      logic       eot;
   } char_want_type;

   localparam stim_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      // Single-byte messages straight after reset: zero, key-cancelling and all-ones bytes.
      '{8'h00, 1'b1, 1'b1, "bQ=="},
      '{8'h6D, 1'b1, 1'b1, "AA=="},
      '{8'hFF, 1'b1, 1'b1, "kg=="},
      // Two-byte message, one pad character.
      '{8'hFF, 1'b0, 1'b0, "    "},
      '{8'h00, 1'b1, 1'b0, "    "},
      // Three-byte message, no padding.
      '{8'h12, 1'b0, 1'b0, "    "},
      '{8'h34, 1'b0, 1'b0, "    "},
      '{8'h56, 1'b1, 1'b0, "    "},
      // Sixteen-byte message, so that the key wraps.
      '{8'h00, 1'b0, 1'b0, "    "},
      '{8'h01, 1'b0, 1'b0, "    "},
      '{8'h80, 1'b0, 1'b0, "    "},
      '{8'h7F, 1'b0, 1'b0, "    "},
      '{8'hAA, 1'b0, 1'b0, "    "},
      '{8'h55, 1'b0, 1'b0, "    "},
      '{8'hFF, 1'b0, 1'b0, "    "},
      '{8'hFE, 1'b0, 1'b0, "    "},
      '{8'h10, 1'b0, 1'b0, "    "},
      '{8'h20, 1'b0, 1'b0, "    "},
      '{8'h40, 1'b0, 1'b0, "    "},
      '{8'h08, 1'b0, 1'b0, "    "},
      '{8'h04, 1'b0, 1'b0, "    "},
      '{8'h02, 1'b0, 1'b0, "    "},
      '{8'hC3, 1'b0, 1'b0, "    "},
      '{8'h3C, 1'b1, 1'b0, "    "}
   };

   logic clock;
   logic reset;

   xkb_req_if req_bus ();
   xkb_rsp_if rsp_bus ();

   xor_key_base64_encoder_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Encoder state as the testbench tracks it.
   logic [3:0] key_pos;
   logic [3:0] pend_bits;
   logic [2:0] pend_count;
   logic [1:0] chars_mod4;

   char_want_type expected_chars [$];
   int            error_count;
   int            chars_received;
   logic          sender_burst;
   logic          receiver_burst;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Works out the characters that one byte produces and advances the tracked state.
   task automatic predict_chars(input logic [7:0] data, input logic last,
                                output logic [XKB_MAX_CHARS-1:0][6:0] batch, output int n);
      logic [7:0]  mixed;
      logic [11:0] acc;
      logic [11:0] shifted;
      logic [5:0]  code;
      int          total;
      n     = 0;
      batch = '0;
      mixed = data ^ MSG_KEY[8*(XKB_KEY_LEN-1-int'(key_pos)) +: 8];
      key_pos = (key_pos == 4'(XKB_KEY_LEN-1)) ? 4'd0 : key_pos + 4'd1;

      // Cut the bit stream into six-bit groups, most significant first.
      acc   = {pend_bits, mixed};
      total = int'(pend_count) + 8;
      while (total >= 6) begin
         total   -= 6;
         shifted  = acc >> total;
         code     = shifted[5:0];
         batch[n] = B64_ALPHABET[8*(63-int'(code)) +: 7];
         n++;
         chars_mod4++;
      end
      pend_bits  = acc[3:0] & 4'((1 << total) - 1);
      pend_count = 3'(total);

      // Close the message: zero-fill leftover bits, then pad to a multiple of four.
      if (last) begin
         if (pend_count != 3'd0) begin
            code     = 6'({2'b00, pend_bits} << (6 - int'(pend_count)));
            batch[n] = B64_ALPHABET[8*(63-int'(code)) +: 7];
            n++;
            chars_mod4++;
         end
         while (chars_mod4 != 2'd0) begin
            batch[n] = XKB_PAD_CHAR;
            n++;
            chars_mod4++;
         end
         key_pos    = 4'd0;
         pend_bits  = 4'd0;
         pend_count = 3'd0;
      end
   endtask

   // Offers one byte after a random gap (none in a burst) and queues its expected characters on acceptance.
   task automatic send_byte(input logic [7:0] data, input logic last,
                            input logic typed, input logic [31:0] typed_chars);
      logic [XKB_MAX_CHARS-1:0][6:0] batch;
      int n;
      int gap;
      char_want_type want;
      gap = sender_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= data;
      req_bus.final_byte <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);

      predict_chars(data, last, batch, n);
      if (typed) begin
         n = 4;
         for (int i = 0; i < 4; i++) begin
            batch[i] = typed_chars[8*(3-i) +: 7];
         end
      end
      for (int i = 0; i < n; i++) begin
         want.ch  = batch[i];
         want.eot = last && (i == n - 1);
         expected_chars = {expected_chars, want};
      end
   endtask

   // Compares one received character with the oldest expectation.
   task automatic check_char(input logic [6:0] ch, input logic eot);
      char_want_type want;
      if (expected_chars.size() == 0) begin
         report_mismatch($sformatf("character 0x%02h arrived with nothing expected", ch));
      end else begin
         want = expected_chars.pop_front();
         if (ch !== want.ch) begin
            report_mismatch($sformatf("out_char 0x%02h, wanted 0x%02h", ch, want.ch));
         end
         if (eot !== want.eot) begin
            report_mismatch($sformatf("end_of_text %b, wanted %b on char 0x%02h",
                                      eot, want.eot, want.ch));
         end
      end
   endtask

   // Stimulus: directed rows, then random messages, then the drain and verdict.
   initial begin
      int random_sent;
      int msg_len;
      req_bus.valid      = 1'b0;
      req_bus.data_byte  = 8'h00;
      req_bus.final_byte = 1'b0;
      reset        = 1'b1;
      key_pos      = 4'd0;
      pend_bits    = 4'd0;
      pend_count   = 3'd0;
      chars_mod4   = 2'd0;
      error_count  = 0;
      sender_burst = 1'b0;
      random_sent  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The long directed message goes without gaps, so that the receiver hold fills the block.
      for (int r = 0; r < ROW_COUNT; r++) begin
         sender_burst = (r >= 8);
         send_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].last,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].chars);
      end

      // Random messages, mostly short, now and then long enough to wrap the key.
      while (random_sent < RANDOM_ITEMS) begin
         msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                               : $urandom_range(1, 10);
         sender_burst = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < msg_len; i++) begin
            send_byte(8'($urandom_range(0, 255)), (i == msg_len - 1), 1'b0, 32'h0);
            random_sent++;
         end
      end
      req_bus.valid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Receiver: random stalls per character, stall-free stretches and one long hold.
   initial begin
      int stall;
      rsp_bus.ready  = 1'b0;
      chars_received = 0;
      receiver_burst = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (chars_received % 16 == 0) begin
            receiver_burst = ($urandom_range(0, 2) == 0);
         end
         if (chars_received == HOLD_AT_CHAR) begin
            stall = HOLD_CYCLES;
         end else begin
            stall = receiver_burst ? 0 : $urandom_range(0, 13);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         check_char(rsp_bus.out_char, rsp_bus.end_of_text);
         chars_received++;
      end
   end

   // Watchdog: ends the run when no transaction completes for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

endmodule

// ----- files.f -----
src/xkb_pkg.sv
src/xkb_if.sv
src/xkb_front.sv
src/xkb_queue.sv
src/xkb_back.sv
src/xor_key_base64_encoder_core.sv
dv/xor_key_base64_encoder_core_test.sv
